>>> src/earp_pkg.sv
// ----------------------------------------------------------------------------
// earp_pkg
// Shared types and constants of the EAP-AKA' response parser: header and
// attribute codes, byte roles, verdict codes, configuration layout.
// ----------------------------------------------------------------------------
package earp_pkg;

  // Default bound on the packet length in bytes
  localparam int unsigned MAX_PACKET_BYTES_DEF = 4096;
  // Longest XRES that can match, in bytes
  localparam int unsigned RES_BYTES_MAX = 16;

  // Header layout
  localparam int unsigned HDR_LEN      = 8;
  localparam int unsigned POS_CODE     = 0;
  localparam int unsigned POS_ID       = 1;
  localparam int unsigned POS_TYPE     = 4;
  localparam int unsigned POS_SUBTYPE  = 5;
  localparam int unsigned SHORT_LIMIT  = HDR_LEN - 1;

  localparam logic [7:0] EAP_CODE_RESPONSE  = 8'd2;
  localparam logic [7:0] EAP_TYPE_AKA_PRIME = 8'd50;
  localparam logic [7:0] SUBTYPE_CHALLENGE  = 8'd1;
  localparam logic [7:0] SUBTYPE_SYNC_FAIL  = 8'd4;

  // Attribute types and lengths
  localparam logic [7:0] AT_RES         = 8'd3;
  localparam logic [7:0] AT_AUTS        = 8'd4;
  localparam logic [7:0] AT_MAC         = 8'd11;
  localparam logic [7:0] MAC_LEN_UNITS  = 8'd5;
  localparam logic [7:0] AUTS_LEN_UNITS = 8'd4;
  localparam logic [9:0] MAC_ATTR_LEN   = 10'd20;
  localparam logic [9:0] AUTS_ATTR_LEN  = 10'd16;
  localparam logic [9:0] VALUE_OFFSET   = 10'd4;
  localparam logic [9:0] OFF_LEN        = 10'd1;
  localparam logic [9:0] OFF_RES_BITS_H = 10'd2;
  localparam logic [9:0] OFF_RES_BITS_L = 10'd3;

  // Header fault codes (same numbering as the verdict)
  localparam logic [2:0] HF_NONE = 3'd0;
  localparam logic [2:0] HF_CODE = 3'd2;
  localparam logic [2:0] HF_TYPE = 3'd3;
  localparam logic [2:0] HF_ID   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_ID       = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_RES_LEN  = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_RES_HIGH = 2'd2;
  localparam logic [1:0] CFG_EXPECTED_RES_LOW  = 2'd3;

  typedef enum logic [1:0] {
    ROLE_OTHER = 2'd0,
    ROLE_MAC   = 2'd1,
    ROLE_AUTS  = 2'd2
  } role_t;

  typedef enum logic [3:0] {
    VERDICT_OK           = 4'd0,
    VERDICT_SHORT        = 4'd1,
    VERDICT_NOT_RESPONSE = 4'd2,
    VERDICT_NOT_AKA      = 4'd3,
    VERDICT_ID_MISMATCH  = 4'd4,
    VERDICT_BAD_ATTR_LEN = 4'd5,
    VERDICT_SYNC_FAIL    = 4'd6,
    VERDICT_NO_MAC       = 4'd7,
    VERDICT_NO_RES       = 4'd8,
    VERDICT_RES_MISMATCH = 4'd9,
    VERDICT_OTHER        = 4'd10,
    VERDICT_TOO_LONG     = 4'd11
  } verdict_t;

  typedef struct packed {
    logic [7:0]   expected_id;
    logic [4:0]   expected_res_len;
    logic [127:0] expected_res;   // byte 0 in bits 127:120
  } earp_cfg_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    role_t      byte_role;
    logic       verdict_valid;
    verdict_t   verdict;
    logic [7:0] subtype_seen;
    logic       auts_present;
    logic       mac_present;
  } earp_result_t;

endpackage

>>> src/earp_in_if.sv
// ----------------------------------------------------------------------------
// earp_in_if
// Byte channel into the parser: one packet byte per transaction.
// ----------------------------------------------------------------------------
interface earp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

>>> src/earp_out_if.sv
// ----------------------------------------------------------------------------
// earp_out_if
// Result channel of the parser: one result per packet byte.
// ----------------------------------------------------------------------------
interface earp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [1:0] byte_role;
  logic       verdict_valid;
  logic [3:0] verdict;
  logic [7:0] subtype_seen;
  logic       auts_present;
  logic       mac_present;

  modport source (output valid, output echo_byte, output byte_role, output verdict_valid,
                  output verdict, output subtype_seen, output auts_present,
                  output mac_present, input ready);
  modport sink   (input valid, input echo_byte, input byte_role, input verdict_valid,
                  input verdict, input subtype_seen, input auts_present,
                  input mac_present, output ready);
endinterface

>>> src/earp_core.sv
// ----------------------------------------------------------------------------
// earp_core
// Per-packet parser state and the combinational update for one byte: header
// checks, attribute walk, XRES compare, MAC zeroing and the final verdict.
// ----------------------------------------------------------------------------
module earp_core
  import earp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         packet_end,
  input  earp_cfg_t    cfg,
  output earp_result_t result
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       hfault_r, hfault_nxt;
  logic [7:0]       subtype_r, subtype_nxt;
  logic [7:0]       atype_r, atype_nxt;
  logic [9:0]       arem_r, arem_nxt;
  logic [9:0]       aoff_r, aoff_nxt;
  logic [15:0]      rbits_r, rbits_nxt;
  logic             rcmp_r, rcmp_nxt;
  logic             rfound_r, rfound_nxt;
  logic             rmatch_r, rmatch_nxt;
  logic             mac_r, mac_nxt;
  logic             auts_r, auts_nxt;
  logic             wfault_r, wfault_nxt;

  logic [15:0][7:0] xres_bytes;
  logic [9:0]       alen;
  logic [9:0]       ridx;
  logic [12:0]      rlen;
  logic [7:0]       echo;
  role_t            role;
  verdict_t         verdict;

  assign xres_bytes = cfg.expected_res;

  // Byte update
  always_comb begin
    pos_nxt     = pos_r;
    hfault_nxt  = hfault_r;
    subtype_nxt = subtype_r;
    atype_nxt   = atype_r;
    arem_nxt    = arem_r;
    aoff_nxt    = aoff_r;
    rbits_nxt   = rbits_r;
    rcmp_nxt    = rcmp_r;
    rfound_nxt  = rfound_r;
    rmatch_nxt  = rmatch_r;
    mac_nxt     = mac_r;
    auts_nxt    = auts_r;
    wfault_nxt  = wfault_r;
    echo        = data_byte;
    role        = ROLE_OTHER;
    alen        = aoff_r + arem_r;
    ridx        = aoff_r - VALUE_OFFSET;
    rlen        = rbits_r[15:3];

    if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
      if (pos_r < POS_W'(HDR_LEN)) begin
        // header checks
        if (pos_r == POS_W'(POS_CODE) && data_byte != EAP_CODE_RESPONSE) begin
          hfault_nxt = HF_CODE;
        end
        if (pos_r == POS_W'(POS_ID) && data_byte != cfg.expected_id &&
            hfault_r == HF_NONE) begin
          hfault_nxt = HF_ID;
        end
        if (pos_r == POS_W'(POS_TYPE) && data_byte != EAP_TYPE_AKA_PRIME &&
            (hfault_r == HF_NONE || hfault_r == HF_ID)) begin
          hfault_nxt = HF_TYPE;
        end
        if (pos_r == POS_W'(POS_SUBTYPE)) begin
          subtype_nxt = data_byte;
        end
      end else if (!wfault_r) begin
        // attribute walk
        if (arem_r == 10'd0) begin
          atype_nxt = data_byte;
          aoff_nxt  = OFF_LEN;
          arem_nxt  = 10'd1;
        end else if (aoff_r == OFF_LEN) begin
          if (data_byte == 8'd0) begin
            wfault_nxt = 1'b1;
            arem_nxt   = 10'd0;
            aoff_nxt   = 10'd0;
          end else begin
            if (atype_r == AT_MAC && data_byte == MAC_LEN_UNITS) mac_nxt = 1'b1;
            if (atype_r == AT_AUTS && data_byte == AUTS_LEN_UNITS) auts_nxt = 1'b1;
            aoff_nxt = OFF_RES_BITS_H;
            arem_nxt = {data_byte, 2'b00} - 10'd2;
          end
        end else begin
          if (atype_r == AT_MAC && alen == MAC_ATTR_LEN && aoff_r >= VALUE_OFFSET) begin
            echo = 8'd0;
            role = ROLE_MAC;
          end else if (atype_r == AT_AUTS && alen == AUTS_ATTR_LEN) begin
            role = ROLE_AUTS;
          end else if (atype_r == AT_RES) begin
            if (aoff_r == OFF_RES_BITS_H) begin
              rbits_nxt = {data_byte, 8'd0};
            end else if (aoff_r == OFF_RES_BITS_L) begin
              rbits_nxt = rbits_r | {8'd0, data_byte};
              rcmp_nxt  = (rbits_nxt[15:3] == {8'd0, cfg.expected_res_len}) &&
                          (cfg.expected_res_len <= 5'(RES_BYTES_MAX));
            end else if ({3'd0, ridx} < rlen && rcmp_r) begin
              if (ridx >= 10'(RES_BYTES_MAX) ||
                  data_byte != xres_bytes[4'd15 - ridx[3:0]]) begin
                rcmp_nxt = 1'b0;
              end
            end
          end
          aoff_nxt = aoff_r + 10'd1;
          arem_nxt = arem_r - 10'd1;
          // end of this attribute
          if (arem_nxt == 10'd0) begin
            if (atype_r == AT_RES) begin
              rfound_nxt = (rbits_nxt[15:3] != 13'd0) &&
                           (14'd4 + {1'b0, rbits_nxt[15:3]} <= {4'd0, alen});
              rmatch_nxt = rcmp_nxt;
            end
            aoff_nxt = 10'd0;
          end
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    // verdict on the final byte
    if (pos_r >= POS_W'(MAX_PACKET_BYTES)) begin
      verdict = VERDICT_TOO_LONG;
    end else if (pos_r < POS_W'(SHORT_LIMIT)) begin
      verdict = VERDICT_SHORT;
    end else if (hfault_nxt != HF_NONE) begin
      verdict = verdict_t'({1'b0, hfault_nxt});
    end else if (wfault_nxt || (arem_nxt != 10'd0 && aoff_nxt != OFF_LEN)) begin
      verdict = VERDICT_BAD_ATTR_LEN;
    end else if (subtype_nxt == SUBTYPE_SYNC_FAIL) begin
      verdict = VERDICT_SYNC_FAIL;
    end else if (subtype_nxt == SUBTYPE_CHALLENGE) begin
      if (!mac_nxt) verdict = VERDICT_NO_MAC;
      else if (!rfound_nxt) verdict = VERDICT_NO_RES;
      else if (!rmatch_nxt) verdict = VERDICT_RES_MISMATCH;
      else verdict = VERDICT_OK;
    end else begin
      verdict = VERDICT_OTHER;
    end

    result.echo_byte     = echo;
    result.byte_role     = role;
    result.verdict_valid = packet_end;
    result.verdict       = packet_end ? verdict : VERDICT_OK;
    result.subtype_seen  = packet_end ? subtype_nxt : 8'd0;
    result.auts_present  = packet_end & auts_nxt;
    result.mac_present   = packet_end & mac_nxt;

    // a new packet starts after the final byte
    if (packet_end) begin
      pos_nxt     = '0;
      hfault_nxt  = HF_NONE;
      subtype_nxt = 8'd0;
      atype_nxt   = 8'd0;
      arem_nxt    = 10'd0;
      aoff_nxt    = 10'd0;
      rbits_nxt   = 16'd0;
      rcmp_nxt    = 1'b0;
      rfound_nxt  = 1'b0;
      rmatch_nxt  = 1'b0;
      mac_nxt     = 1'b0;
      auts_nxt    = 1'b0;
      wfault_nxt  = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hfault_r  <= HF_NONE;
      subtype_r <= 8'd0;
      atype_r   <= 8'd0;
      arem_r    <= 10'd0;
      aoff_r    <= 10'd0;
      rbits_r   <= 16'd0;
      rcmp_r    <= 1'b0;
      rfound_r  <= 1'b0;
      rmatch_r  <= 1'b0;
      mac_r     <= 1'b0;
      auts_r    <= 1'b0;
      wfault_r  <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      hfault_r  <= hfault_nxt;
      subtype_r <= subtype_nxt;
      atype_r   <= atype_nxt;
      arem_r    <= arem_nxt;
      aoff_r    <= aoff_nxt;
      rbits_r   <= rbits_nxt;
      rcmp_r    <= rcmp_nxt;
      rfound_r  <= rfound_nxt;
      rmatch_r  <= rmatch_nxt;
      mac_r     <= mac_nxt;
      auts_r    <= auts_nxt;
      wfault_r  <= wfault_nxt;
    end
  end

endmodule

>>> src/eap_aka_response_parser.sv
// ----------------------------------------------------------------------------
// eap_aka_response_parser
// Byte-serial checker for decoded EAP-AKA' responses.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock while the result side keeps up and returns
// one result per byte: the byte lands in an input register, then the parser
// updates its header and attribute counters and the result register. With the
// result side ready, a byte is accepted every cycle for any packet length; the
// single parser update per byte sets that rate. Each byte is echoed with the
// AT_MAC value bytes zeroed and tagged for an external HMAC engine; AUTS bytes
// are tagged too. The result for the byte marked as the packet end carries the
// verdict. The user must write configuration through the cfg_ port only while
// no bytes are in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module eap_aka_response_parser
  import earp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  earp_in_if.sink     in_chan,
  earp_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  earp_cfg_t    cfg_r, cfg_nxt;
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_end_r;
  logic         out_valid_r, out_valid_nxt;
  earp_result_t out_res_r;
  earp_result_t result;
  logic         out_free;
  logic         step;
  logic         in_fire;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_ID:       cfg_nxt.expected_id            = cfg_data[7:0];
        CFG_EXPECTED_RES_LEN:  cfg_nxt.expected_res_len       = cfg_data[4:0];
        CFG_EXPECTED_RES_HIGH: cfg_nxt.expected_res[127:64]   = cfg_data;
        CFG_EXPECTED_RES_LOW:  cfg_nxt.expected_res[63:0]     = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake and stage control
  assign out_free     = !out_valid_r || out_chan.ready;
  assign step         = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire      = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.data_byte;
      s1_end_r  <= in_chan.packet_end;
    end
  end

  earp_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (s1_byte_r),
    .packet_end (s1_end_r),
    .cfg        (cfg_r),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.echo_byte     = out_res_r.echo_byte;
  assign out_chan.byte_role     = out_res_r.byte_role;
  assign out_chan.verdict_valid = out_res_r.verdict_valid;
  assign out_chan.verdict       = out_res_r.verdict;
  assign out_chan.subtype_seen  = out_res_r.subtype_seen;
  assign out_chan.auts_present  = out_res_r.auts_present;
  assign out_chan.mac_present   = out_res_r.mac_present;

endmodule

>>> test/tb_eap_aka_response_parser.sv
// ----------------------------------------------------------------------------
// tb_eap_aka_response_parser
// Self-checking bench for the byte-serial EAP-AKA' response parser. Packets
// go in one byte per transaction, and every result is compared field by field
// with a behavioural model of the parser kept in this file. A short table of
// hand-made packets comes first. Random packets follow, mostly well-formed
// challenge and sync-failure responses with mutations mixed in, under several
// register settings. Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module tb_eap_aka_response_parser;
  import earp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES    = MAX_PACKET_BYTES_DEF;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_BYTES  = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   verdict;
    logic [7:0] subtype;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  earp_in_if  in_chan ();
  earp_out_if out_chan ();

  eap_aka_response_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register shadow
  logic [7:0]   cfg_id;
  logic [4:0]   cfg_res_len;
  logic [127:0] cfg_res;

  // Parser state of the model
  logic [15:0] pos;
  logic [2:0]  hdr_fault;
  logic [7:0]  sub_held;
  logic [7:0]  at_type;
  logic [9:0]  at_left;
  logic [9:0]  at_off;
  logic [15:0] res_bits;
  logic        res_ok, res_seen, res_hit, mac_seen, auts_seen, len_fault;

  earp_result_t pending_results[$];
  logic [7:0]   pkt[$];
  int unsigned  errors;
  int unsigned  results_seen;
  int unsigned  rand_bytes;
  bit           gaps_on;
  bit           hold_req;
  bit           cur_typed;
  earp_result_t cur_want;

  // Hand-made packets; verdict rows carry their expected result
  step_t directed_steps [28] = '{
    '{8'hFF,              1'b1, 1'b1, VERDICT_SHORT,        8'h00},
    // other subtype, ending on a lone attribute type byte
    '{EAP_CODE_RESPONSE,  1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h09,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{EAP_TYPE_AKA_PRIME, 1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h0A,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{AT_MAC,             1'b1, 1'b1, VERDICT_OTHER,        8'h0A},
    // wrong code outranks the other header faults
    '{8'h01,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h05,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h08,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h33,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{SUBTYPE_SYNC_FAIL,  1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b1, 1'b1, VERDICT_NOT_RESPONSE, SUBTYPE_SYNC_FAIL},
    // zero attribute length
    '{EAP_CODE_RESPONSE,  1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h0A,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{EAP_TYPE_AKA_PRIME, 1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{SUBTYPE_CHALLENGE,  1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{AT_MAC,             1'b0, 1'b0, VERDICT_OK,           8'h00},
    '{8'h00,              1'b1, 1'b1, VERDICT_BAD_ATTR_LEN, SUBTYPE_CHALLENGE}
  };

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] xres(int unsigned i);
    return cfg_res[127 - 8 * i -: 8];
  endfunction

  function automatic void clear_walk();
    pos = '0; hdr_fault = HF_NONE; sub_held = '0; at_type = '0;
    at_left = '0; at_off = '0; res_bits = '0;
    res_ok = 1'b0; res_seen = 1'b0; res_hit = 1'b0;
    mac_seen = 1'b0; auts_seen = 1'b0; len_fault = 1'b0;
  endfunction

  // Model of the parser: one result per accepted byte
  function automatic earp_result_t parse_byte(logic [7:0] b, logic last);
    earp_result_t r;
    int unsigned  p, off, alen, rlen;
    r = '0;
    r.echo_byte = b;
    r.byte_role = ROLE_OTHER;
    p = pos;
    if (p < MAX_BYTES) begin
      if (p < HDR_LEN) begin
        // header: faults only steer the verdict
        if (p == POS_CODE && b != EAP_CODE_RESPONSE) hdr_fault = HF_CODE;
        if (p == POS_ID && b != cfg_id && hdr_fault == HF_NONE) hdr_fault = HF_ID;
        if (p == POS_TYPE && b != EAP_TYPE_AKA_PRIME &&
            (hdr_fault == HF_NONE || hdr_fault == HF_ID)) hdr_fault = HF_TYPE;
        if (p == POS_SUBTYPE) sub_held = b;
      end else if (!len_fault) begin
        if (at_left == 0) begin
          // attribute type byte
          at_type = b;
          at_off  = OFF_LEN;
          at_left = 10'd1;
        end else if (at_off == OFF_LEN) begin
          // length byte, in 4-byte units
          if (b == 8'd0) begin
            len_fault = 1'b1;
            at_left   = '0;
            at_off    = '0;
          end else begin
            if (at_type == AT_MAC && b == MAC_LEN_UNITS) mac_seen = 1'b1;
            if (at_type == AT_AUTS && b == AUTS_LEN_UNITS) auts_seen = 1'b1;
            at_off  = OFF_RES_BITS_H;
            at_left = {b, 2'b00} - 10'd2;
          end
        end else begin
          off  = at_off;
          alen = off + at_left;
          if (at_type == AT_MAC && alen == MAC_ATTR_LEN && off >= VALUE_OFFSET) begin
            r.echo_byte = 8'd0;
            r.byte_role = ROLE_MAC;
          end else if (at_type == AT_AUTS && alen == AUTS_ATTR_LEN) begin
            r.byte_role = ROLE_AUTS;
          end else if (at_type == AT_RES) begin
            if (off == OFF_RES_BITS_H) begin
              res_bits = {b, 8'h00};
            end else if (off == OFF_RES_BITS_L) begin
              res_bits = res_bits | b;
              rlen     = res_bits >> 3;
              res_ok   = (rlen == cfg_res_len) && (cfg_res_len <= RES_BYTES_MAX);
            end else begin
              rlen = res_bits >> 3;
              if (off - VALUE_OFFSET < rlen && res_ok &&
                  (off - VALUE_OFFSET >= RES_BYTES_MAX || b != xres(off - VALUE_OFFSET)))
                res_ok = 1'b0;
            end
          end
          at_off  = at_off + 10'd1;
          at_left = at_left - 10'd1;
          if (at_left == 0) begin
            // last AT_RES wins
            if (at_type == AT_RES) begin
              rlen     = res_bits >> 3;
              res_seen = rlen > 0 && VALUE_OFFSET + rlen <= alen;
              res_hit  = res_ok;
            end
            at_off = '0;
          end
        end
      end
      pos = p + 1;
    end

    if (last) begin
      if (p >= MAX_BYTES)
        r.verdict = VERDICT_TOO_LONG;
      else if (p + 1 < HDR_LEN)
        r.verdict = VERDICT_SHORT;
      else if (hdr_fault != HF_NONE)
        r.verdict = verdict_t'({1'b0, hdr_fault});  // fault codes share the numbering
      else if (len_fault || (at_left != 0 && at_off != OFF_LEN))
        r.verdict = VERDICT_BAD_ATTR_LEN;
      else if (sub_held == SUBTYPE_SYNC_FAIL)
        r.verdict = VERDICT_SYNC_FAIL;
      else if (sub_held == SUBTYPE_CHALLENGE)
        r.verdict = !mac_seen ? VERDICT_NO_MAC :
                    !res_seen ? VERDICT_NO_RES :
                    !res_hit  ? VERDICT_RES_MISMATCH : VERDICT_OK;
      else
        r.verdict = VERDICT_OTHER;
      r.verdict_valid = 1'b1;
      r.subtype_seen  = sub_held;
      r.auts_present  = auts_seen;
      r.mac_present   = mac_seen;
      clear_walk();
    end
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH %s", msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
  endtask

  // Predict on accepted bytes, check on accepted results
  always @(posedge clk) begin
    earp_result_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        want = parse_byte(in_chan.data_byte, in_chan.packet_end);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("echo_byte",     out_chan.echo_byte,     want.echo_byte);
          check_field("byte_role",     out_chan.byte_role,     want.byte_role);
          check_field("verdict_valid", out_chan.verdict_valid, want.verdict_valid);
          check_field("verdict",       out_chan.verdict,       want.verdict);
          check_field("subtype_seen",  out_chan.subtype_seen,  want.subtype_seen);
          check_field("auts_present",  out_chan.auts_present,  want.auts_present);
          check_field("mac_present",   out_chan.mac_present,   want.mac_present);
        end
      end
    end
  end

  // Result side: random stalls, long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_chan.ready <= !(gaps_on && $urandom_range(99) < 11);
    end
  end

  // One byte transaction; returns on the falling edge after acceptance
  task automatic send_byte(logic [7:0] b, logic last, logic typed, earp_result_t want);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    cur_typed = typed;
    cur_want  = want;
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= b;
    in_chan.packet_end <= last;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
    rand_bytes += pkt.size();
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_chan.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      CFG_EXPECTED_ID:       cfg_id = d[7:0];
      CFG_EXPECTED_RES_LEN:  cfg_res_len = d[4:0];
      CFG_EXPECTED_RES_HIGH: cfg_res[127:64] = d;
      CFG_EXPECTED_RES_LOW:  cfg_res[63:0] = d;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] id, logic [4:0] res_len, logic [63:0] hi,
                            logic [63:0] lo);
    drain();
    write_reg(CFG_EXPECTED_ID, {56'd0, id});
    write_reg(CFG_EXPECTED_RES_LEN, {59'd0, res_len});
    write_reg(CFG_EXPECTED_RES_HIGH, hi);
    write_reg(CFG_EXPECTED_RES_LOW, lo);
  endtask

  // Generic attribute: type, length in units, random value
  task automatic add_attr(logic [7:0] kind, int unsigned units);
    pkt.push_back(kind);
    pkt.push_back(8'(units));
    repeat (units * 4 - 2) pkt.push_back(8'($urandom));
  endtask

  // AT_RES built mostly from the configured XRES, sometimes bent
  task automatic add_res();
    int unsigned nbytes, units, bits;
    logic [7:0]  v;
    nbytes = ($urandom_range(99) < 85) ? cfg_res_len : $urandom_range(0, 20);
    bits   = nbytes * 8;
    if ($urandom_range(99) < 10) bits = bits + $urandom_range(0, 7);
    if ($urandom_range(99) < 4) bits = $urandom_range(0, 16'hFFFF);
    units = (nbytes + 7) / 4;
    if ($urandom_range(99) < 6) units++;
    pkt.push_back(AT_RES);
    pkt.push_back(8'(units));
    pkt.push_back(bits[15:8]);
    pkt.push_back(bits[7:0]);
    for (int unsigned i = 0; i < units * 4 - 4; i++) begin
      if (i < nbytes && i < RES_BYTES_MAX) v = xres(i);
      else if (i < nbytes) v = 8'($urandom);
      else v = 8'h00;
      if ($urandom_range(99) < 3) v = v ^ 8'(1 << $urandom_range(0, 7));
      pkt.push_back(v);
    end
  endtask

  task automatic add_mac();
    add_attr(AT_MAC, ($urandom_range(99) < 10) ? $urandom_range(1, 6) : MAC_LEN_UNITS);
  endtask

  task automatic add_auts();
    add_attr(AT_AUTS, ($urandom_range(99) < 10) ? $urandom_range(1, 6) : AUTS_LEN_UNITS);
  endtask

  task automatic add_header(logic [7:0] subtype);
    pkt.push_back(($urandom_range(99) < 4) ? 8'($urandom) : EAP_CODE_RESPONSE);
    pkt.push_back(($urandom_range(99) < 4) ? 8'($urandom) : cfg_id);
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    pkt.push_back(($urandom_range(99) < 4) ? 8'($urandom) : EAP_TYPE_AKA_PRIME);
    pkt.push_back(subtype);
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
  endtask

  // Random packet: mostly well-formed, some noise and damage
  task automatic make_packet();
    int unsigned r, s, m, idx;
    pkt.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      return;
    end
    s = $urandom_range(99);
    add_header(s < 60 ? SUBTYPE_CHALLENGE : s < 75 ? SUBTYPE_SYNC_FAIL : 8'($urandom));
    if ($urandom_range(99) < 50) begin
      // typical challenge answer
      if ($urandom_range(1)) begin
        add_res();
        add_mac();
      end else begin
        add_mac();
        add_res();
      end
      if ($urandom_range(99) < 20) add_auts();
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(3))
          0: add_res();
          1: add_mac();
          2: add_auts();
          default: add_attr(8'($urandom), $urandom_range(1, 4));
        endcase
      end
    end
    m = $urandom_range(99);
    if (m < 6) begin
      idx = $urandom_range(0, pkt.size() - 1);
      pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
    end else if (m < 12) begin
      idx = $urandom_range(1, pkt.size());
      while (pkt.size() > idx) void'(pkt.pop_back());
    end else if (m < 17) begin
      pkt.push_back(8'($urandom));
    end else if (m < 20) begin
      pkt.push_back(8'($urandom));
      pkt.push_back(8'h00);
    end
  endtask

  task automatic run_random(int unsigned n);
    rand_bytes = 0;
    while (rand_bytes < n) begin
      make_packet();
      send_packet();
    end
  endtask

  // Stimulus
  initial begin
    earp_result_t want;
    errors       = 0;
    results_seen = 0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    cur_typed    = 1'b0;
    cur_want     = '0;
    cfg_id       = '0;
    cfg_res_len  = '0;
    cfg_res      = '0;
    clear_walk();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_EXPECTED_ID;
    cfg_data           <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.data_byte  <= '0;
    in_chan.packet_end <= 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hand-made packets under reset settings
    foreach (directed_steps[i]) begin
      want = '0;
      want.echo_byte     = directed_steps[i].data;
      want.verdict_valid = 1'b1;
      want.verdict       = directed_steps[i].verdict;
      want.subtype_seen  = directed_steps[i].subtype;
      send_byte(directed_steps[i].data, directed_steps[i].last, directed_steps[i].typed,
                want);
    end

    // Ordinary settings under a long receiver hold-off
    set_config(8'h5A, 5'd8, {$urandom, $urandom}, {$urandom, $urandom});
    hold_req = 1'b1;
    run_random(PHASE_BYTES);

    // All ones
    set_config(8'hFF, 5'd16, '1, '1);
    run_random(PHASE_BYTES);

    // All zeros, receiver hold-off at the start
    set_config(8'h00, 5'd0, '0, '0);
    hold_req = 1'b1;
    run_random(PHASE_BYTES);

    // XRES length beyond the maximum never matches
    set_config(8'($urandom), 5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    run_random(PHASE_BYTES);

    // Short XRES, no stalls on either side
    set_config(8'($urandom), 5'd4, {$urandom, $urandom}, {$urandom, $urandom});
    gaps_on = 1'b0;
    run_random(PHASE_BYTES);
    gaps_on = 1'b1;

    set_config(8'($urandom), 5'($urandom_range(1, 16)), {$urandom, $urandom},
               {$urandom, $urandom});
    run_random(PHASE_BYTES);

    // Let the pipeline empty out
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_eap_aka_response_parser: done, clean");
    else
      $display("tb_eap_aka_response_parser: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_eap_aka_response_parser: done, errors");
    $finish;
  end

endmodule
